>>> hw/rtl/gtst_pkg.sv
// ----------------------------------------------------------------------------
// gtst_pkg
// Shared codes and field widths for the generation-tagged slot table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gtst_pkg;

   localparam int MODE_W   = 2;
   localparam int INDEX_W  = 8;
   localparam int VALUE_W  = 64;
   localparam int STATUS_W = 2;
   localparam int GRANT_W  = 5;

   typedef logic [MODE_W-1:0]   mode_type;
   typedef logic [STATUS_W-1:0] status_type;

   localparam mode_type MODE_ALLOC = 2'd0;
   localparam mode_type MODE_FREE  = 2'd1;
   localparam mode_type MODE_GET   = 2'd2;
   localparam mode_type MODE_SET   = 2'd3;

   localparam status_type ST_OK      = 2'd0;
   localparam status_type ST_INVALID = 2'd1;
   localparam status_type ST_NOSLOT  = 2'd2;

endpackage

`default_nettype wire

>>> hw/rtl/generation_tagged_slot_table_top.sv
// ----------------------------------------------------------------------------
// generation_tagged_slot_table_top
// Slot allocator with a busy map and per-slot generation, value and tag.
//
// Request word (req_*): mode, slot_index, write_value; one response word
// (rsp_*) per request: status, granted_slot, read_value.
// Each request passes two states: in S_IDLE the accept issues a read of the
// slot's row from the slot memory; in S_EXEC the row is modified, written
// back and the response register loaded. A new request is accepted only
// in S_IDLE, after the previous one has left S_EXEC.
// Allocate picks the lowest free slot from the busy map in the accept cycle.
// Reset clears the busy map and the per-row valid bits; a row never written
// reads as all zero. No clearing pass is needed.
// When the receiver stalls, the finished word waits in the response
// register; a following request is still accepted and its result holds in
// the execute cycle until the response register frees up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module generation_tagged_slot_table_top #(
   parameter int SLOTS    = 32,
   parameter int GEN_BITS = 32
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_valid,
   output logic                                req_ready,
   input  wire  [gtst_pkg::MODE_W-1:0]         req_mode,
   input  wire  [gtst_pkg::INDEX_W-1:0]        req_slot_index,
   input  wire  [gtst_pkg::VALUE_W-1:0]        req_write_value,
   output logic                                rsp_valid,
   input  wire                                 rsp_ready,
   output logic [gtst_pkg::STATUS_W-1:0]       rsp_status,
   output logic [gtst_pkg::GRANT_W-1:0]        rsp_granted_slot,
   output logic [gtst_pkg::VALUE_W-1:0]        rsp_read_value
);

   localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int ROW_W = 2 * GEN_BITS + gtst_pkg::VALUE_W;
   localparam int VAL_LO = 0;
   localparam int TAG_LO = gtst_pkg::VALUE_W;
   localparam int GEN_LO = gtst_pkg::VALUE_W + GEN_BITS;

   localparam logic S_IDLE = 1'b0;
   localparam logic S_EXEC = 1'b1;

   logic state_ff, state_in;

   logic [ROW_W-1:0] mem [SLOTS];
   logic [ROW_W-1:0] rd_data_ff;
   logic             rd_valid_ff;
   logic [SLOTS-1:0] entry_valid_ff;
   logic [SLOTS-1:0] busy_ff;

   gtst_pkg::mode_type            op_mode_ff;
   logic [SW-1:0]                 op_slot_ff;
   logic                          op_in_range_ff;
   logic                          op_found_ff;
   logic [gtst_pkg::VALUE_W-1:0]  op_wval_ff;

   logic                          rsp_valid_ff;
   gtst_pkg::status_type          rsp_status_ff, rsp_status_in;
   logic [gtst_pkg::GRANT_W-1:0]  rsp_grant_ff, rsp_grant_in;
   logic [gtst_pkg::VALUE_W-1:0]  rsp_rval_ff, rsp_rval_in;

   logic                 accept, can_load, done;
   logic                 req_in_range, free_found;
   logic [SW-1:0]        free_slot, rd_addr;
   logic [ROW_W-1:0]     row;
   logic [GEN_BITS-1:0]  cur_gen, cur_tag, bumped_gen;
   logic [gtst_pkg::VALUE_W-1:0] cur_val;
   logic                 mem_we;
   logic [ROW_W-1:0]     wr_row;
   logic                 busy_set, busy_clr;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign can_load  = !rsp_valid_ff || rsp_ready;
   assign done      = (state_ff == S_EXEC) && can_load;

   assign req_in_range = ({1'b0, req_slot_index} < (gtst_pkg::INDEX_W + 1)'(SLOTS));

   always_comb begin
      free_found = 1'b0;
      free_slot  = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (!busy_ff[i]) begin
            free_found = 1'b1;
            free_slot  = SW'(i);
         end
      end
   end

   always_comb begin
      rd_addr = '0;
      if (req_mode == gtst_pkg::MODE_ALLOC) begin
         rd_addr = free_slot;
      end else if (req_in_range) begin
         rd_addr = req_slot_index[SW-1:0];
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:  if (accept) state_in = S_EXEC;
         S_EXEC:  if (can_load) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_mode_ff     <= req_mode;
         op_slot_ff     <= rd_addr;
         op_in_range_ff <= req_in_range;
         op_found_ff    <= free_found;
         op_wval_ff     <= req_write_value;
         rd_data_ff     <= mem[rd_addr];
         rd_valid_ff    <= entry_valid_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[op_slot_ff] <= wr_row;
      end
   end

   assign row     = rd_valid_ff ? rd_data_ff : '0;
   assign cur_gen = row[GEN_LO +: GEN_BITS];
   assign cur_tag = row[TAG_LO +: GEN_BITS];
   assign cur_val = row[VAL_LO +: gtst_pkg::VALUE_W];

   always_comb begin
      bumped_gen = cur_gen + GEN_BITS'(1);
      if (bumped_gen == '0) begin
         bumped_gen = GEN_BITS'(1);
      end
   end

   always_comb begin
      mem_we        = 1'b0;
      wr_row        = row;
      busy_set      = 1'b0;
      busy_clr      = 1'b0;
      rsp_status_in = gtst_pkg::ST_OK;
      rsp_grant_in  = '0;
      rsp_rval_in   = '0;
      if (op_mode_ff == gtst_pkg::MODE_ALLOC) begin
         if (op_found_ff) begin
            mem_we       = done;
            busy_set     = done;
            wr_row       = {bumped_gen, bumped_gen, {gtst_pkg::VALUE_W{1'b0}}};
            rsp_grant_in = gtst_pkg::GRANT_W'(op_slot_ff);
         end else begin
            rsp_status_in = gtst_pkg::ST_NOSLOT;
         end
      end else if (!op_in_range_ff) begin
         rsp_status_in = gtst_pkg::ST_INVALID;
      end else begin
         case (op_mode_ff)
            gtst_pkg::MODE_FREE: begin
               if (busy_ff[op_slot_ff]) begin
                  mem_we   = done;
                  busy_clr = done;
                  wr_row   = {bumped_gen, cur_tag, cur_val};
               end else begin
                  rsp_status_in = gtst_pkg::ST_INVALID;
               end
            end
            gtst_pkg::MODE_GET: begin
               if (cur_tag == cur_gen) begin
                  rsp_rval_in = cur_val;
               end
            end
            gtst_pkg::MODE_SET: begin
               mem_we = done;
               wr_row = {cur_gen, cur_gen, op_wval_ff};
            end
            default: begin
               rsp_status_in = gtst_pkg::ST_INVALID;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff        <= '0;
         entry_valid_ff <= '0;
      end else begin
         if (busy_set) busy_ff[op_slot_ff] <= 1'b1;
         if (busy_clr) busy_ff[op_slot_ff] <= 1'b0;
         if (mem_we)   entry_valid_ff[op_slot_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (done) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (done) begin
         rsp_status_ff <= rsp_status_in;
         rsp_grant_ff  <= rsp_grant_in;
         rsp_rval_ff   <= rsp_rval_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_granted_slot = rsp_grant_ff;
   assign rsp_read_value   = rsp_rval_ff;

endmodule

`default_nettype wire
